// ===== rtl/core/tlg_pkg.sv =====
// Shared constants, codes and types for the toroidal life generation block.
// No dependencies; every other file of the block refers to it by scoped names.
package tlg_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int SIZE_W    = 7;
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MIN_SIZE  = 3;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_GEN   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

    typedef logic [MAX_COLS-1:0] row_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic take_tail;
        logic load;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/tlg_cell.sv =====
// One row of the grid: a link of the row ring.
// Depends on tlg_pkg for the row type and the control bundle.
module tlg_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  tlg_pkg::cell_ctrl_t ctrl,
    input  tlg_pkg::row_t     next_row,
    input  tlg_pkg::row_t     tail_row,
    output tlg_pkg::row_t     row_q
);

    tlg_pkg::row_t row_reg;
    tlg_pkg::row_t row_next;

    always_comb
    begin
        row_next = row_reg;
        priority if (ctrl.clear)
        begin
            row_next = '0;
        end
        else if (ctrl.load)
        begin
            row_next = tail_row;
        end
        else if (ctrl.shift)
        begin
            row_next = ctrl.take_tail ? tail_row : next_row;
        end
        else
        begin
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row_q = row_reg;

endmodule

// ===== rtl/core/tlg_rule.sv =====
// Next-generation logic for one row, with column wrap at the width in use.
// Depends on tlg_pkg for sizes and the row type.
module tlg_rule (
    input  tlg_pkg::row_t                   above,
    input  tlg_pkg::row_t                   here,
    input  tlg_pkg::row_t                   below,
    input  logic [tlg_pkg::SIZE_W-1:0]      nc,
    output tlg_pkg::row_t                   fresh
);

    logic [2:0][tlg_pkg::MAX_COLS-1:0] win;
    logic [2:0][tlg_pkg::MAX_COLS-1:0] win_l;
    logic [2:0][tlg_pkg::MAX_COLS-1:0] win_r;
    logic [tlg_pkg::COL_W-1:0]         nc_m1;

    assign win   = {below, here, above};
    assign nc_m1 = tlg_pkg::COL_W'(nc - 1'b1);

    for (genvar k = 0; k < 3; k++)
    begin : g_line
        for (genvar c = 0; c < tlg_pkg::MAX_COLS; c++)
        begin : g_col
            if (c == 0)
            begin : g_left_wrap
                assign win_l[k][c] = win[k][nc_m1];
            end
            else
            begin : g_left
                assign win_l[k][c] = win[k][c-1];
            end
            if (c == tlg_pkg::MAX_COLS - 1)
            begin : g_right_wrap
                assign win_r[k][c] = win[k][0];
            end
            else
            begin : g_right
                assign win_r[k][c] = (nc_m1 == tlg_pkg::COL_W'(c)) ? win[k][0] : win[k][c+1];
            end
        end
    end

    for (genvar c = 0; c < tlg_pkg::MAX_COLS; c++)
    begin : g_cnt
        logic [3:0] n;
        logic       in_use;

        assign n = 4'(win_l[0][c]) + 4'(win[0][c]) + 4'(win_r[0][c])
                 + 4'(win_l[1][c]) + 4'(win_r[1][c])
                 + 4'(win_l[2][c]) + 4'(win[2][c]) + 4'(win_r[2][c]);
        assign in_use = tlg_pkg::SIZE_W'(c) < nc;
        assign fresh[c] = !in_use ? here[c]
                        : ((n == 4'd3) || (here[c] && (n == 4'd2)));
    end

endmodule

// ===== rtl/core/toroidal_life_generation.sv =====
// Top level of the toroidal life block: row ring, sequencer, config, output register.
// Depends on tlg_pkg, tlg_cell and tlg_rule.
//
// The grid is a ring of row cells; every opcode but clear walks the rows in use
// through the head of the ring, one row per cycle. Clear goes straight to the
// finish state without a walk; a generation updates each row with the one row
// update unit at the head of the ring. One item is worked at a time; a new item
// is taken while the previous result still waits in the output register.
module toroidal_life_generation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tlg_pkg::OP_W-1:0]         opcode,
    input  logic [tlg_pkg::COL_W-1:0]        col,
    input  logic [tlg_pkg::ROW_W-1:0]        row,
    input  logic                             cell_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             cell_out,
    output logic [tlg_pkg::OP_W-1:0]         op_done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlg_pkg::SIZE_W-1:0]       cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [tlg_pkg::SIZE_W-1:0]    cols_reg, rows_reg;
    logic [tlg_pkg::CNT_W-1:0]     cnt_reg, end_cnt_reg;
    logic [tlg_pkg::OP_W-1:0]      op_reg;
    logic [tlg_pkg::COL_W-1:0]     col_reg;
    logic [tlg_pkg::ROW_W-1:0]     sel_row_reg;
    logic                          val_reg;
    logic                          inside_reg;
    logic                          rd_bit_reg;
    tlg_pkg::row_t                 prior_reg;
    tlg_pkg::row_t                 copy_reg;
    logic                          out_valid_reg;
    logic                          cell_out_reg;
    logic [tlg_pkg::OP_W-1:0]      op_done_reg;

    logic [tlg_pkg::SIZE_W-1:0]    nc, nr, nr_m1;
    logic                          in_xfer, is_gen, gen_last, walk_last;
    logic                          shift_now, load_now, hit, out_free;
    tlg_pkg::row_t                 rows_q [tlg_pkg::MAX_ROWS];
    tlg_pkg::row_t                 head, below, fresh, tail_in;

    always_comb
    begin
        priority if (cols_reg < tlg_pkg::SIZE_W'(tlg_pkg::MIN_SIZE))
            nc = tlg_pkg::SIZE_W'(tlg_pkg::MIN_SIZE);
        else if (cols_reg > tlg_pkg::SIZE_W'(tlg_pkg::MAX_COLS))
            nc = tlg_pkg::SIZE_W'(tlg_pkg::MAX_COLS);
        else
            nc = cols_reg;
        priority if (rows_reg < tlg_pkg::SIZE_W'(tlg_pkg::MIN_SIZE))
            nr = tlg_pkg::SIZE_W'(tlg_pkg::MIN_SIZE);
        else if (rows_reg > tlg_pkg::SIZE_W'(tlg_pkg::MAX_ROWS))
            nr = tlg_pkg::SIZE_W'(tlg_pkg::MAX_ROWS);
        else
            nr = rows_reg;
    end

    assign nr_m1     = nr - 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign is_gen    = (op_reg == tlg_pkg::OP_GEN);
    assign walk_last = (cnt_reg == end_cnt_reg);
    assign gen_last  = is_gen && walk_last;
    assign shift_now = (state_reg == S_WALK) && !gen_last;
    assign load_now  = (state_reg == S_WALK) && gen_last;
    assign hit       = inside_reg && (cnt_reg == tlg_pkg::CNT_W'(sel_row_reg));
    assign out_free  = !out_valid_reg || !out_stall;

    // ring of rows; cell MAX_ROWS-1 has no successor
    for (genvar i = 0; i < tlg_pkg::MAX_ROWS; i++)
    begin : g_ring
        tlg_pkg::cell_ctrl_t ctrl;
        tlg_pkg::row_t       nxt;

        assign ctrl.clear     = in_xfer && (opcode == tlg_pkg::OP_CLEAR);
        assign ctrl.shift     = shift_now && (tlg_pkg::SIZE_W'(i) < nr);
        assign ctrl.take_tail = (tlg_pkg::SIZE_W'(i) == nr_m1);
        assign ctrl.load      = load_now && (i == 0);

        if (i == tlg_pkg::MAX_ROWS - 1)
        begin : g_end
            assign nxt = '0;
        end
        else
        begin : g_mid
            assign nxt = rows_q[i+1];
        end

        tlg_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .next_row (nxt),
            .tail_row (tail_in),
            .row_q    (rows_q[i])
        );
    end

    assign head  = rows_q[0];
    assign below = gen_last ? copy_reg : rows_q[1];

    tlg_rule u_rule (
        .above (prior_reg),
        .here  (head),
        .below (below),
        .nc    (nc),
        .fresh (fresh)
    );

    always_comb
    begin
        tail_in = head;
        unique case (op_reg)
            tlg_pkg::OP_GEN:
            begin
                if (cnt_reg != '0)
                begin
                    tail_in = fresh;
                end
            end
            tlg_pkg::OP_WRITE:
            begin
                if (hit)
                begin
                    tail_in[col_reg] = val_reg;
                end
            end
            default:
            begin
                tail_in = head;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (opcode == tlg_pkg::OP_CLEAR) ? S_FIN : S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cols_reg      <= tlg_pkg::SIZE_W'(tlg_pkg::MAX_COLS);
            rows_reg      <= tlg_pkg::SIZE_W'(tlg_pkg::MAX_ROWS);
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tlg_pkg::CFG_COLS)
                    cols_reg <= cfg_data;
                else if (cfg_index == tlg_pkg::CFG_ROWS)
                    rows_reg <= cfg_data;
            end
            if (in_xfer)
                cnt_reg <= '0;
            else if (state_reg == S_WALK)
                cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg      <= opcode;
            col_reg     <= col;
            sel_row_reg <= row;
            val_reg     <= cell_in;
            inside_reg  <= (tlg_pkg::SIZE_W'(col) < nc) && (tlg_pkg::SIZE_W'(row) < nr);
            end_cnt_reg <= (opcode == tlg_pkg::OP_GEN) ? tlg_pkg::CNT_W'(nr)
                                                       : tlg_pkg::CNT_W'(nr_m1);
            rd_bit_reg  <= 1'b0;
        end
        else if (state_reg == S_WALK)
        begin
            if (op_reg == tlg_pkg::OP_READ && hit)
                rd_bit_reg <= head[col_reg];
            if (is_gen)
            begin
                prior_reg <= head;
                if (cnt_reg == tlg_pkg::CNT_W'(1))
                    copy_reg <= head;
            end
        end
        if (state_reg == S_FIN && out_free)
        begin
            op_done_reg  <= op_reg;
            cell_out_reg <= (op_reg == tlg_pkg::OP_READ) ? rd_bit_reg : 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign op_done   = op_done_reg;

endmodule

// ===== rtl/core/tlg_checker.sv =====
// Port-level checks of toroidal_life_generation, attached by the bind below.
// Depends on tlg_pkg for opcode values.
module tlg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [tlg_pkg::OP_W-1:0]         opcode,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             cell_out,
    input logic [tlg_pkg::OP_W-1:0]         op_done
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_out) && $stable(op_done))
        else $error("stalled result changed");

    // one item in flight: busy right after a transfer in
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after transfer");

    // only a read reports a live cell
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cell_out |-> op_done == tlg_pkg::OP_READ)
        else $error("cell_out set on a non-read result");

    // a clear taken while no result is shown comes out carrying the clear opcode
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == tlg_pkg::OP_CLEAR) && !out_valid
        |=> ##1 out_valid && (op_done == tlg_pkg::OP_CLEAR))
        else $error("clear result missing or wrong opcode");

endmodule

bind toroidal_life_generation tlg_checker u_tlg_checker (.*);
